// ===== sv/grid_cell_offset_table_unit_macros.svh =====
// Assertion macros for the grid cell offset table unit.
// Expect clk and arst_n in the scope of use; empty when SYNTH is defined.
`ifndef GRID_CELL_OFFSET_TABLE_UNIT_MACROS_SVH
`define GRID_CELL_OFFSET_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
// property holds at every edge outside reset
`define GCOT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define GCOT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GCOT_ASSERT(lbl, prop, msg)
`define GCOT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/gcot_pkg.sv =====
// Shared constants, codes and types of the grid cell offset table unit.
// No dependencies.
package gcot_pkg;

	localparam int POS_W      = 16;
	localparam int CFG_W      = 16;
	localparam int GRID_F_W   = 5;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int OUT_CNT_W  = 17;
	localparam int REG_IDX_W  = 1;
	localparam int DIV_STEPS  = POS_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam int GRID_DIM_DEF      = 32;
	localparam int MAX_PARTICLES_DEF = 65536;

	localparam logic [CFG_W-1:0] CELL_SIZE_RST = CFG_W'(16);

	localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 1'd1;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADSPAN = 3'd4;

	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] dividend;
		logic [POS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/gcot_ifs.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on gcot_pkg for field widths.
interface gcot_item_if import gcot_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [GRID_F_W-1:0] row;
	logic [GRID_F_W-1:0] first_col;
	logic [GRID_F_W-1:0] last_col;

	modport source (output valid, command, pos_x, pos_y, row, first_col, last_col,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, row, first_col, last_col,
		output ready);
endinterface

interface gcot_result_if import gcot_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [OUT_CNT_W-1:0] range_start;
	logic [OUT_CNT_W-1:0] range_end;
	logic [OUT_CNT_W-1:0] total_count;

	modport source (output valid, status, range_start, range_end, total_count,
		input ready);
	modport sink (input valid, status, range_start, range_end, total_count,
		output ready);
endinterface

// ===== sv/gcot_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gcot_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/gcot_div.sv =====
// Restoring divider, one quotient bit per cycle, shared for x and y.
// Depends on gcot_pkg.
module gcot_div import gcot_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     rem_q;
	logic [POS_W-1:0]     quo_q;
	logic [POS_W-1:0]     dvs_q;
	logic [POS_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[POS_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits POS_W bits
			rem_q <= fits ? POS_W'(trial - {1'b0, dvs_q}) : trial[POS_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== sv/grid_cell_offset_table_unit.sv =====
// Grid cell start-offset table: top level. Uses gcot_pkg, gcot_ifs, gcot_ram, gcot_div.
// Reset: clearing pass over all GRID_DIM*GRID_DIM cells (1024 by default), item.ready low meanwhile.
// Insert/remove divide x then y, read the table and sweep every later cell, the sweep paced
// by the single RAM write port; outside/full skip the reads and an empty cell skips the sweep.
// One item at a time: the next beat can be taken in the same cycle as the result appears,
// later if the previous result beat is stalled.
`include "grid_cell_offset_table_unit_macros.svh"
module grid_cell_offset_table_unit import gcot_pkg::*; #(
	parameter int GRID_DIM      = GRID_DIM_DEF,
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gcot_item_if.sink            item,
	gcot_result_if.source        result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	localparam int CELLS  = GRID_DIM * GRID_DIM;
	localparam int CELL_W = $clog2(CELLS);
	localparam int IDX_W  = CELL_W + 1;             // can hold CELLS itself
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_DIVX  = 4'd2;
	localparam logic [3:0] S_DIVY  = 4'd3;
	localparam logic [3:0] S_LOC   = 4'd4;
	localparam logic [3:0] S_RD0   = 4'd5;
	localparam logic [3:0] S_RD1   = 4'd6;
	localparam logic [3:0] S_RD2   = 4'd7;
	localparam logic [3:0] S_EVAL  = 4'd8;
	localparam logic [3:0] S_SWEEP = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]          state_q;

	// configuration
	logic [CFG_W-1:0]    cell_w_q;
	logic [CFG_W-1:0]    cell_h_q;

	// latched command beat
	logic [CMD_W-1:0]    cmd_q;
	logic [POS_W-1:0]    pos_x_q;
	logic [POS_W-1:0]    pos_y_q;
	logic [GRID_F_W-1:0] row_q;
	logic [GRID_F_W-1:0] fc_q;
	logic [GRID_F_W-1:0] lc_q;

	// working registers
	logic [POS_W-1:0]    cx_q;
	logic [POS_W-1:0]    cy_q;
	logic [CELL_W-1:0]   cell_a_q;   // cell whose start gives range_start
	logic [IDX_W-1:0]    cell_b_q;   // cell whose start gives range_end, CELLS = past the end
	logic [CNT_W-1:0]    rs_q;
	logic [CNT_W-1:0]    re_q;
	logic [CNT_W-1:0]    total_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    idx_q;      // sweep index, clear and adjust
	logic                clear_res_q;
	logic                div_go_q;

	// sweep read-modify-write pipeline
	logic                sweep_v_s1;
	logic [CELL_W-1:0]   sweep_addr_s1;

	// result register
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CNT_W-1:0]    res_rs_q;
	logic [CNT_W-1:0]    res_re_q;
	logic [CNT_W-1:0]    res_total_q;

	// RAM port
	logic                ram_we;
	logic [CELL_W-1:0]   ram_waddr;
	logic [CNT_W-1:0]    ram_wdata;
	logic [CELL_W-1:0]   ram_raddr;
	logic [CNT_W-1:0]    ram_rdata;

	// divider
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// locate / span decode
	logic                is_query;
	logic [31:0]         base;
	logic [31:0]         col_a;
	logic [31:0]         col_b;
	logic                outside;
	logic                bad_span;
	logic                b_in_range;
	logic                sweep_issue;
	logic                in_acc;
	logic                res_load;

	assign in_acc   = item.valid && item.ready;
	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	//--------------------------------------------------------------------
	// Configuration registers, to be written only while idle; the block does not enforce this
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q <= CELL_SIZE_RST;
			cell_h_q <= CELL_SIZE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CELL_WIDTH:  cell_w_q <= wr_data;
				REG_CELL_HEIGHT: cell_h_q <= wr_data;
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Shared divider: x / width first, then y / height. Zero size acts as one.
	//--------------------------------------------------------------------
	always_comb begin
		div_req.start = div_go_q;
		if (state_q == S_DIVY) begin
			div_req.dividend = pos_y_q;
			div_req.divisor  = (cell_h_q == '0) ? POS_W'(1) : cell_h_q;
		end else begin
			div_req.dividend = pos_x_q;
			div_req.divisor  = (cell_w_q == '0) ? POS_W'(1) : cell_w_q;
		end
	end

	gcot_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	//--------------------------------------------------------------------
	// Cell decode. One constant multiply by GRID_DIM serves both the
	// located cell of insert/remove and the row base of a query.
	//--------------------------------------------------------------------
	assign is_query   = (cmd_q == CMD_QUERY);
	assign base       = (is_query ? 32'(row_q) : 32'(cy_q)) * GRID_DIM;
	assign col_a      = is_query ? 32'(fc_q) : 32'(cx_q);
	assign col_b      = is_query ? 32'(lc_q) : 32'(cx_q);
	assign outside    = (32'(cx_q) >= GRID_DIM) || (32'(cy_q) >= GRID_DIM);
	assign bad_span   = (32'(row_q) >= GRID_DIM) || (32'(lc_q) >= GRID_DIM) || (fc_q > lc_q);
	assign b_in_range = cell_b_q < IDX_W'(CELLS);
	assign sweep_issue = idx_q < IDX_W'(CELLS);

	//--------------------------------------------------------------------
	// Offset table RAM. Clear writes zero a word a cycle; the adjust sweep
	// reads word i while writing word i-1 back with +1 or -1.
	//--------------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[CELL_W-1:0];
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_SWEEP) begin
			ram_we    = sweep_v_s1;
			ram_waddr = sweep_addr_s1;
			ram_wdata = (cmd_q == CMD_INSERT) ? ram_rdata + CNT_W'(1) : ram_rdata - CNT_W'(1);
		end
	end

	always_comb begin
		case (state_q)
			S_RD1:   ram_raddr = cell_b_q[CELL_W-1:0];   // unused when past the end
			S_SWEEP: ram_raddr = idx_q[CELL_W-1:0];
			default: ram_raddr = cell_a_q;
		endcase
	end

	gcot_ram #(
		.WIDTH (CNT_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	//--------------------------------------------------------------------
	// Sequencer and its control state
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;         // clearing pass after reset
			idx_q       <= '0;
			total_q     <= '0;
			clear_res_q <= 1'b0;
			div_go_q    <= 1'b0;
			sweep_v_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (item.command)
							CMD_CLEAR: begin
								state_q     <= S_CLEAR;
								idx_q       <= '0;
								total_q     <= '0;
								clear_res_q <= 1'b1;
							end
							CMD_INSERT, CMD_REMOVE: begin
								state_q  <= S_DIVX;
								div_go_q <= 1'b1;
							end
							default: state_q <= S_LOC;
						endcase
					end
				end
				S_CLEAR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(CELLS - 1)) begin
						state_q <= clear_res_q ? S_DONE : S_IDLE;
					end
				end
				S_DIVX: begin
					if (div_rsp.done) begin
						state_q  <= S_DIVY;
						div_go_q <= 1'b1;
					end
				end
				S_DIVY: begin
					if (div_rsp.done) begin
						state_q <= S_LOC;
					end
				end
				S_LOC: begin
					if (is_query ? bad_span :
							(outside || (cmd_q == CMD_INSERT &&
							total_q >= CNT_W'(MAX_PARTICLES)))) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_EVAL;
				S_EVAL: begin
					idx_q      <= cell_b_q;
					sweep_v_s1 <= 1'b0;
					if (is_query || (cmd_q == CMD_REMOVE && re_q <= rs_q)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SWEEP;
						total_q <= (cmd_q == CMD_INSERT) ? total_q + CNT_W'(1) :
							total_q - CNT_W'(1);
					end
				end
				S_SWEEP: begin
					sweep_v_s1 <= sweep_issue;
					if (sweep_issue) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (!sweep_v_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Payload registers
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		sweep_addr_s1 <= idx_q[CELL_W-1:0];
		if (in_acc) begin
			cmd_q    <= item.command;
			pos_x_q  <= item.pos_x;
			pos_y_q  <= item.pos_y;
			row_q    <= item.row;
			fc_q     <= item.first_col;
			lc_q     <= item.last_col;
			status_q <= ST_OK;
			rs_q     <= '0;
			re_q     <= '0;
		end
		if (state_q == S_DIVX && div_rsp.done) begin
			cx_q <= div_rsp.quotient;
		end
		if (state_q == S_DIVY && div_rsp.done) begin
			cy_q <= div_rsp.quotient;
		end
		if (state_q == S_LOC) begin
			cell_a_q <= CELL_W'(base + col_a);
			cell_b_q <= IDX_W'(base + col_b + 32'd1);
			// precedence: outside grid, then table full
			if (is_query) begin
				if (bad_span) begin
					status_q <= ST_BADSPAN;
				end
			end else if (outside) begin
				status_q <= ST_OUTSIDE;
			end else if (cmd_q == CMD_INSERT && total_q >= CNT_W'(MAX_PARTICLES)) begin
				status_q <= ST_FULL;
			end
		end
		if (state_q == S_RD1) begin
			rs_q <= ram_rdata;
		end
		if (state_q == S_RD2) begin
			re_q <= b_in_range ? ram_rdata : total_q;
		end
		if (state_q == S_EVAL && !is_query) begin
			// start of the touched cell never moves; its end moves by one
			if (cmd_q == CMD_INSERT) begin
				re_q <= re_q + CNT_W'(1);
			end else if (re_q <= rs_q) begin
				status_q <= ST_EMPTY;
			end else begin
				re_q <= re_q - CNT_W'(1);
			end
		end
		if (res_load) begin
			res_status_q <= status_q;
			res_rs_q     <= rs_q;
			res_re_q     <= re_q;
			res_total_q  <= total_q;
		end
	end

	//--------------------------------------------------------------------
	// Ports
	//--------------------------------------------------------------------
	assign item.ready         = (state_q == S_IDLE);
	assign result.valid       = res_valid_q;
	assign result.status      = res_status_q;
	assign result.range_start = OUT_CNT_W'(res_rs_q);
	assign result.range_end   = OUT_CNT_W'(res_re_q);
	assign result.total_count = OUT_CNT_W'(res_total_q);

	//--------------------------------------------------------------------
	// Checks
	//--------------------------------------------------------------------
	`GCOT_ASSERT(a_total_bound, total_q <= CNT_W'(MAX_PARTICLES),
		"particle total above capacity")
	`GCOT_ASSERT(a_div_in_seq, div_rsp.done |-> (state_q == S_DIVX || state_q == S_DIVY),
		"divider finished outside its states")
	`GCOT_ASSERT(a_sweep_later_cells,
		(state_q == S_SWEEP && ram_we) |-> (IDX_W'(ram_waddr) >= cell_b_q),
		"sweep wrote the touched cell or an earlier one")
	`GCOT_ASSERT_NEXT(a_result_loaded, res_load, res_valid_q && state_q == S_IDLE,
		"result not presented after completion")

endmodule

// ===== verif/tb_grid_cell_offset_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_cell_offset_table_unit: directed and random command beats.
// Depends on gcot_pkg, gcot_ifs and the unit's RTL; a tracker class predicts every result beat.
module tb_grid_cell_offset_table_unit import gcot_pkg::*; ();

	localparam int GRID           = GRID_DIM_DEF;
	localparam int CELLS          = GRID * GRID;
	localparam int MAX_COUNT      = MAX_PARTICLES_DEF;
	localparam int PHASES         = 6;
	localparam int PHASE_BEATS    = 92;
	localparam int SETTLE_CYCLES  = 32;
	// longest quiet stretch: clearing pass or a full insert sweep plus both stalls
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [GRID_F_W-1:0] row;
		logic [GRID_F_W-1:0] first_col;
		logic [GRID_F_W-1:0] last_col;
	} cmd_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_CNT_W-1:0] range_start;
		logic [OUT_CNT_W-1:0] range_end;
		logic [OUT_CNT_W-1:0] total_count;
	} span_beat_t;

	// Own copy of the offset table; predicts the span beat for each accepted command
	// and holds the predictions until the unit hands its results back.
	class cell_table_tracker;
		logic [OUT_CNT_W-1:0] start_of [CELLS];
		logic [OUT_CNT_W-1:0] total;
		logic [CFG_W-1:0]     cell_w;
		logic [CFG_W-1:0]     cell_h;
		span_beat_t           awaited [$];
		int unsigned          bad;
		int unsigned          checked;
		int unsigned          per_cmd [4];
		int unsigned          per_status [8];

		function new();
			foreach (start_of[i]) start_of[i] = '0;
			total = '0;
			cell_w = CELL_SIZE_RST;
			cell_h = CELL_SIZE_RST;
			bad = 0;
			checked = 0;
			foreach (per_cmd[i]) per_cmd[i] = 0;
			foreach (per_status[i]) per_status[i] = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_CELL_WIDTH)
				cell_w = val;
			else if (idx == REG_CELL_HEIGHT)
				cell_h = val;
		endfunction

		// start of the following cell, or the count past the last cell
		function logic [OUT_CNT_W-1:0] next_start(int unsigned c);
			return (c < CELLS) ? start_of[c] : total;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function void note_command(cmd_beat_t c);
			span_beat_t r;
			int unsigned w, h, cx, cy, cell_no, base, k;
			r.status = ST_OK;
			r.range_start = '0;
			r.range_end = '0;
			case (c.command)
				CMD_CLEAR: begin
					foreach (start_of[i]) start_of[i] = '0;
					total = '0;
				end
				CMD_INSERT, CMD_REMOVE: begin
					// a zero cell size behaves as one pixel
					w = (cell_w == 0) ? 1 : cell_w;
					h = (cell_h == 0) ? 1 : cell_h;
					cx = c.pos_x / w;
					cy = c.pos_y / h;
					if (cx >= GRID || cy >= GRID) begin
						r.status = ST_OUTSIDE;
					end else begin
						cell_no = cy * GRID + cx;
						if (c.command == CMD_INSERT) begin
							if (total >= MAX_COUNT) begin
								r.status = ST_FULL;
							end else begin
								for (k = cell_no + 1; k < CELLS; k++)
									start_of[k] = start_of[k] + 1'b1;
								total = total + 1'b1;
								r.range_start = start_of[cell_no];
								r.range_end = next_start(cell_no + 1);
							end
						end else begin
							r.range_start = start_of[cell_no];
							r.range_end = next_start(cell_no + 1);
							if (r.range_end <= r.range_start) begin
								r.status = ST_EMPTY;
							end else begin
								for (k = cell_no + 1; k < CELLS; k++)
									start_of[k] = start_of[k] - 1'b1;
								total = total - 1'b1;
								r.range_start = start_of[cell_no];
								r.range_end = next_start(cell_no + 1);
							end
						end
					end
				end
				default: begin
					if (c.row >= GRID || c.last_col >= GRID || c.first_col > c.last_col) begin
						r.status = ST_BADSPAN;
					end else begin
						base = c.row * GRID;
						r.range_start = start_of[base + c.first_col];
						r.range_end = next_start(base + c.last_col + 1);
					end
				end
			endcase
			r.total_count = total;
			awaited.push_back(r);
			per_cmd[c.command]++;
			per_status[r.status]++;
		endfunction

		function void check_result(span_beat_t got);
			span_beat_t want;
			bit differs;
			checked++;
			if (awaited.size() == 0) begin
				bad++;
				if (bad <= REPORT_LIMIT)
					$display("[%0t] result beat with nothing outstanding: %0d %0d..%0d %0d",
						$time, got.status, got.range_start, got.range_end,
						got.total_count);
				return;
			end
			want = awaited.pop_front();
			differs = (got.status !== want.status) ||
				(got.range_start !== want.range_start) ||
				(got.range_end !== want.range_end) || (got.total_count !== want.total_count);
			if (differs) begin
				bad++;
				if (bad <= REPORT_LIMIT)
					$display({"[%0t] result %0d: status %0d/%0d start %0d/%0d ",
						"end %0d/%0d total %0d/%0d (got/exp)"},
						$time, checked, got.status, want.status, got.range_start,
						want.range_start, got.range_end, want.range_end,
						got.total_count, want.total_count);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	gcot_item_if   item_ch ();
	gcot_result_if result_ch ();

	cell_table_tracker tracker;
	bit                idling_on;
	int unsigned       placed_cells [$];  // cells recently inserted into, steers removes

	// cell sizes per random phase: reset size, one pixel, widest, exact fit, zero, uneven
	logic [CFG_W-1:0] phase_width  [PHASES] = '{16, 1, 65535, 2048, 0, 300};
	logic [CFG_W-1:0] phase_height [PHASES] = '{16, 1, 65535, 2048, 0, 7};
	bit               phase_idle   [PHASES] = '{1, 1, 0, 1, 1, 0};

	grid_cell_offset_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result sink: ready drops at random while idling is on.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0)
				stall_left--;
			else if (idling_on && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 17);
			result_ch.ready <= arst_n && (stall_left == 0);
		end
	end

	// Beat monitor and watchdog. The result is checked before the new command is noted:
	// the result at any edge always belongs to an older command.
	initial begin : beat_monitor
		int unsigned quiet;
		span_beat_t  got;
		cmd_beat_t   cmd;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			quiet++;
			if (arst_n) begin
				if (result_ch.valid && result_ch.ready) begin
					got.status      = result_ch.status;
					got.range_start = result_ch.range_start;
					got.range_end   = result_ch.range_end;
					got.total_count = result_ch.total_count;
					tracker.check_result(got);
					quiet = 0;
				end
				if (item_ch.valid && item_ch.ready) begin
					cmd.command   = item_ch.command;
					cmd.pos_x     = item_ch.pos_x;
					cmd.pos_y     = item_ch.pos_y;
					cmd.row       = item_ch.row;
					cmd.first_col = item_ch.first_col;
					cmd.last_col  = item_ch.last_col;
					tracker.note_command(cmd);
					quiet = 0;
				end
			end
		end
		$display("[%0t] no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_grid_cell_offset_table_unit NOT OK");
		$finish;
	end

	function automatic cmd_beat_t beat(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y,
			int unsigned r, int unsigned fc, int unsigned lc);
		cmd_beat_t b;
		b.command   = cmd;
		b.pos_x     = x[POS_W-1:0];
		b.pos_y     = y[POS_W-1:0];
		b.row       = r[GRID_F_W-1:0];
		b.first_col = fc[GRID_F_W-1:0];
		b.last_col  = lc[GRID_F_W-1:0];
		return b;
	endfunction

	// Mostly in-grid positions for the current cell size, removes aimed at filled cells,
	// mostly well-formed spans; the rest is raw noise.
	function automatic cmd_beat_t random_beat();
		cmd_beat_t   b;
		int unsigned pick, w, h, cell_no, idx, x, y;
		b = beat(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 2)
			b.command = CMD_CLEAR;
		else if (pick < 50)
			b.command = CMD_INSERT;
		else if (pick < 75)
			b.command = CMD_REMOVE;
		if ((b.command == CMD_INSERT || b.command == CMD_REMOVE) &&
				$urandom_range(0, 99) < 85) begin
			w = (tracker.cell_w == 0) ? 1 : tracker.cell_w;
			h = (tracker.cell_h == 0) ? 1 : tracker.cell_h;
			cell_no = $urandom_range(0, CELLS - 1);
			if (b.command == CMD_REMOVE && placed_cells.size() != 0 &&
					$urandom_range(0, 9) < 7) begin
				idx = $urandom_range(0, placed_cells.size() - 1);
				cell_no = placed_cells[idx];
				placed_cells.delete(idx);
			end else if (b.command == CMD_INSERT) begin
				placed_cells.push_back(cell_no);
				if (placed_cells.size() > 64)
					void'(placed_cells.pop_front());
			end
			x = (cell_no % GRID) * w + $urandom_range(0, w - 1);
			y = (cell_no / GRID) * h + $urandom_range(0, h - 1);
			// no pixel maps to this column or row at this size
			if (x > 16'hFFFF) x = $urandom_range(0, 16'hFFFF);
			if (y > 16'hFFFF) y = $urandom_range(0, 16'hFFFF);
			b.pos_x = x[POS_W-1:0];
			b.pos_y = y[POS_W-1:0];
		end else if (b.command == CMD_QUERY && $urandom_range(0, 9) != 0) begin
			b.last_col = $urandom_range(b.first_col, GRID - 1);
		end
		return b;
	endfunction

	task automatic send_beat(input cmd_beat_t b);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.command   <= b.command;
		item_ch.pos_x     <= b.pos_x;
		item_ch.pos_y     <= b.pos_y;
		item_ch.row       <= b.row;
		item_ch.first_col <= b.first_col;
		item_ch.last_col  <= b.last_col;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// Hold off the sender until every predicted result has come back, then let the unit settle.
	task automatic await_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		tracker.set_reg(idx, val);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned ph, n;
		tracker = new();
		idling_on = 1'b1;
		arst_n    <= 1'b0;
		wr_en     <= 1'b0;
		wr_index  <= '0;
		wr_data   <= '0;
		item_ch.valid     <= 1'b0;
		item_ch.command   <= CMD_CLEAR;
		item_ch.pos_x     <= '0;
		item_ch.pos_y     <= '0;
		item_ch.row       <= '0;
		item_ch.first_col <= '0;
		item_ch.last_col  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset cell size of 16 x 16 pixels.
		send_beat(beat(CMD_QUERY, 0, 0, 0, 0, GRID - 1));      // empty table
		send_beat(beat(CMD_INSERT, 0, 0, 0, 0, 0));            // first cell
		send_beat(beat(CMD_INSERT, 511, 511, 0, 0, 0));        // last cell, end is the count
		send_beat(beat(CMD_INSERT, 100, 37, 0, 0, 0));
		send_beat(beat(CMD_INSERT, 100, 37, 0, 0, 0));
		send_beat(beat(CMD_INSERT, 512, 0, 0, 0, 0));          // column just past the grid
		send_beat(beat(CMD_INSERT, 0, 512, 0, 0, 0));          // row just past the grid
		send_beat(beat(CMD_INSERT, 65535, 65535, 0, 0, 0));
		send_beat(beat(CMD_REMOVE, 65535, 0, 0, 0, 0));        // outside beats the empty check
		send_beat(beat(CMD_REMOVE, 511, 511, 0, 0, 0));
		send_beat(beat(CMD_REMOVE, 511, 511, 0, 0, 0));        // now empty
		send_beat(beat(CMD_REMOVE, 300, 300, 0, 0, 0));        // never filled
		send_beat(beat(CMD_QUERY, 0, 0, 2, 0, GRID - 1));
		send_beat(beat(CMD_QUERY, 0, 0, GRID - 1, GRID - 1, GRID - 1));
		send_beat(beat(CMD_QUERY, 0, 0, 0, 0, 0));
		send_beat(beat(CMD_QUERY, 0, 0, 5, 9, 8));             // first past last
		send_beat(beat(CMD_QUERY, 65535, 65535, GRID - 1, GRID - 1, 0));
		send_beat(beat(CMD_CLEAR, 65535, 65535, GRID - 1, GRID - 1, GRID - 1));
		send_beat(beat(CMD_QUERY, 0, 0, 2, 0, GRID - 1));      // after clear
		send_beat(beat(CMD_INSERT, 15, 15, 0, 0, 0));
		send_beat(beat(CMD_REMOVE, 15, 15, 0, 0, 0));
		await_results();

		// Random phases, one cell size each; registers change only once the unit is idle.
		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_CELL_WIDTH, phase_width[ph]);
			write_reg(REG_CELL_HEIGHT, phase_height[ph]);
			idling_on = phase_idle[ph];
			for (n = 0; n < PHASE_BEATS; n++) begin
				if (ph == 1 && n == PHASE_BEATS / 2)
					await_results();
				send_beat(random_beat());
			end
			await_results();
		end

		$display("covered %0d clear, %0d insert, %0d remove, %0d query beats over %0d cell sizes",
			tracker.per_cmd[CMD_CLEAR], tracker.per_cmd[CMD_INSERT],
			tracker.per_cmd[CMD_REMOVE], tracker.per_cmd[CMD_QUERY], PHASES);
		$display("statuses: ok %0d, outside %0d, empty %0d, bad span %0d; %0d results, %0d wrong",
			tracker.per_status[ST_OK], tracker.per_status[ST_OUTSIDE],
			tracker.per_status[ST_EMPTY], tracker.per_status[ST_BADSPAN],
			tracker.checked, tracker.bad);
		if (tracker.bad == 0 && tracker.outstanding() == 0)
			$display("tb_grid_cell_offset_table_unit OK");
		else
			$display("tb_grid_cell_offset_table_unit NOT OK");
		$finish;
	end

endmodule
